// ===== src/bcsa_pkg.sv =====
// Shared types and constants of the contiguous sector allocator.
`default_nettype none
package bcsa_pkg;

  localparam int DEF_NUM_SECTORS  = 256;
  localparam int DEF_SECTOR_BYTES = 512;

  // map rows: sectors held in one RAM word
  localparam int ROW_BITS = 8;

  localparam int START_W  = 8;
  localparam int COUNT_W  = 9;
  localparam int BYTES_W  = 18;
  localparam int TOTAL_W  = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;

  localparam logic [START_W-1:0] START_RESET = 8'd4;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd196;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX   = 6'd63;

  localparam logic [CFG_IDX_W-1:0] REG_DATA_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_COUNT = 1'b1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic STAT_OK       = 1'b0;
  localparam logic STAT_NO_SPACE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_PREP,
    ST_SCAN,
    ST_FILL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic prep;
    logic scan_step;
    logic wr_start;
    logic wr_step;
    logic clr_step;
    logic resp_ld;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic scan_done;
    logic found;
    logic wr_done;
    logic clr_last;
    logic op_free;
  } stat_t;

endpackage
`default_nettype wire

// ===== src/bcsa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bcsa_ram
  import bcsa_pkg::*;
#(
  parameter int WIDTH = ROW_BITS,
  parameter int DEPTH = DEF_NUM_SECTORS / ROW_BITS
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/bcsa_ctrl.sv =====
// Request sequencer: clear pass, size division, scan, map update, result.
`default_nettype none
module bcsa_ctrl
  import bcsa_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  wire logic  out_tready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   can_load;

  assign can_load   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (stat.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_tvalid) state_nxt = ST_DIV;
      ST_DIV:   if (stat.div_done) state_nxt = ST_PREP;
      ST_PREP:  state_nxt = stat.op_free ? ST_FILL : ST_SCAN;
      ST_SCAN: begin
        if (stat.scan_done) begin
          state_nxt = stat.found ? ST_FILL : ST_DONE;
        end
      end
      ST_FILL:  if (stat.wr_done) state_nxt = ST_DONE;
      ST_DONE:  if (can_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_CLEAR: cmd.clr_step = 1'b1;
      ST_IDLE:  cmd.load = in_tvalid;
      ST_DIV:   cmd.div_step = !stat.div_done;
      ST_PREP:  cmd.prep = 1'b1;
      ST_SCAN: begin
        cmd.scan_step = !stat.scan_done;
        cmd.wr_start  = stat.scan_done && stat.found;
      end
      ST_FILL:  cmd.wr_step = !stat.wr_done;
      ST_DONE:  cmd.resp_ld = can_load;
      default:  cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.resp_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/bcsa_dp.sv =====
// Datapath: size divider, row-wise map scan, map read-modify-write, count.
`default_nettype none
module bcsa_dp
  import bcsa_pkg::*;
#(
  parameter int NUM_SECTORS  = DEF_NUM_SECTORS,
  parameter int SECTOR_BYTES = DEF_SECTOR_BYTES
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cmd_t               cmd,
  output stat_t                   stat,
  input  wire logic               in_opcode,
  input  wire logic [BYTES_W-1:0] in_size_bytes,
  input  wire logic [START_W-1:0] in_run_start,
  input  wire logic [START_W-1:0] win_start,
  input  wire logic [COUNT_W-1:0] data_count,
  output logic                    res_status,
  output logic [START_W-1:0]      res_granted_start,
  output logic [TOTAL_W-1:0]      res_allocation_total
);

  localparam int ROWS   = (NUM_SECTORS + ROW_BITS - 1) / ROW_BITS;
  localparam int RW     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ROW_SH = $clog2(ROW_BITS);
  localparam int PW     = $clog2(NUM_SECTORS + 1024);
  localparam int CNT_W  = $clog2(NUM_SECTORS + 2);
  localparam int DW     = BYTES_W + 1;
  localparam int DCW    = 1;
  // floor(x / SECTOR_BYTES) == (x * RECIP) >> RSH for every DW-bit x
  localparam int SB_LOG = $clog2(SECTOR_BYTES);
  localparam int RSH    = DW + SB_LOG;
  localparam int MW     = DW + 1;
  localparam int PRW    = DW + MW + SB_LOG;
  localparam longint unsigned RECIP = ((64'd1 << RSH) / 64'(SECTOR_BYTES)) + 64'd1;

  // request
  logic                 op_r;
  logic [START_W-1:0]   first_r;

  // sector count: dvd_r holds the rounded-up size, then the quotient
  logic [DW-1:0]        dvd_r;
  logic [DCW-1:0]       div_cnt_r;
  logic [PRW-1:0]       prod;
  logic [CNT_W-1:0]     need_c;

  // scan / write walker
  logic [CNT_W-1:0]     need_r;
  logic [PW-1:0]        base_r, based_r, lo_r, lim_r;
  logic                 pend_r, set_r, found_r;
  logic [CNT_W-1:0]     run_r;
  logic [PW-1:0]        at_r;
  logic [PW-1:0]        win_end, win_lim, frun_end, frun_lim;
  logic                 issue;

  logic [CNT_W-1:0]     run_nxt;
  logic [PW-1:0]        at_nxt;
  logic                 found_nxt;
  logic [ROW_BITS-1:0]  mask, wr_row;

  // map RAM
  logic [ROW_BITS-1:0]  rdata;
  logic                 ram_we;
  logic [RW-1:0]        ram_waddr, ram_raddr;
  logic [ROW_BITS-1:0]  ram_wdata;
  logic [RW-1:0]        clr_r;

  logic [TOTAL_W-1:0]   count_r, count_nxt;
  logic                 fail;

  // ---- divider ----
  assign prod   = PRW'(dvd_r) * PRW'(RECIP);
  assign need_c = (dvd_r > DW'(NUM_SECTORS)) ? CNT_W'(NUM_SECTORS + 1) : dvd_r[CNT_W-1:0];

  // ---- window and free-run bounds ----
  assign win_end  = PW'(win_start) + PW'(data_count);
  assign win_lim  = (win_end > PW'(NUM_SECTORS)) ? PW'(NUM_SECTORS) : win_end;
  assign frun_end = PW'(first_r) + PW'(need_c);
  assign frun_lim = (frun_end > PW'(NUM_SECTORS)) ? PW'(NUM_SECTORS) : frun_end;

  assign issue = (cmd.scan_step || cmd.wr_step) && (base_r < lim_r) &&
                 !(cmd.scan_step && found_r);

  // one row of first-fit tracking, lowest sector first
  always_comb begin
    logic [PW-1:0] idx;
    idx       = '0;
    run_nxt   = run_r;
    at_nxt    = at_r;
    found_nxt = found_r;
    mask      = '0;
    for (int j = 0; j < ROW_BITS; j++) begin
      idx = based_r + PW'(j);
      mask[j] = (idx >= lo_r) && (idx < lim_r);
      if (pend_r && !found_nxt) begin
        if (mask[j] && !rdata[j]) begin
          if (run_nxt == '0) begin
            at_nxt = idx;
          end
          run_nxt = run_nxt + CNT_W'(1);
          if (run_nxt == need_r) begin
            found_nxt = 1'b1;
          end
        end else begin
          run_nxt = '0;
        end
      end
    end
  end

  assign wr_row = set_r ? (rdata | mask) : (rdata & ~mask);

  // ---- RAM ports ----
  assign ram_raddr = base_r[ROW_SH +: RW];
  always_comb begin
    if (cmd.clr_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = cmd.wr_step && pend_r;
      ram_waddr = based_r[ROW_SH +: RW];
      ram_wdata = wr_row;
    end
  end

  bcsa_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (ROWS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // ---- count and result ----
  assign fail = (op_r == OP_ALLOC) && !found_r;
  always_comb begin
    count_nxt = count_r;
    if (op_r == OP_FREE) begin
      if (count_r != '0) count_nxt = count_r - TOTAL_W'(1);
    end else if (!fail) begin
      if (count_r < TOTAL_MAX) count_nxt = count_r + TOTAL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      clr_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_r <= clr_r + RW'(1);
      if (cmd.resp_ld) count_r <= count_nxt;
      if (cmd.scan_step || cmd.wr_step) begin
        pend_r <= issue;
      end else if (cmd.prep || cmd.wr_start) begin
        pend_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_opcode;
      first_r   <= in_run_start;
      dvd_r     <= DW'(in_size_bytes) + DW'(SECTOR_BYTES - 1);
      div_cnt_r <= DCW'(1);
    end else if (cmd.div_step) begin
      dvd_r     <= prod[RSH +: DW];
      div_cnt_r <= div_cnt_r - DCW'(1);
    end

    priority if (cmd.prep) begin
      need_r <= need_c;
      run_r  <= '0;
      if (op_r == OP_FREE) begin
        set_r  <= 1'b0;
        lo_r   <= PW'(first_r);
        lim_r  <= frun_lim;
        base_r <= PW'({first_r[START_W-1:ROW_SH], ROW_SH'(0)});
        // unused on free
        found_r <= 1'b0;
        at_r    <= '0;
      end else begin
        set_r  <= 1'b1;
        lo_r   <= PW'(win_start);
        lim_r  <= win_lim;
        base_r <= PW'({win_start[START_W-1:ROW_SH], ROW_SH'(0)});
        // a zero-size request fits at the window start
        found_r <= (need_c == '0);
        at_r    <= PW'(win_start);
      end
    end else if (cmd.wr_start) begin
      lo_r   <= at_r;
      lim_r  <= at_r + PW'(need_r);
      base_r <= {at_r[PW-1:ROW_SH], ROW_SH'(0)};
    end else if (cmd.scan_step || cmd.wr_step) begin
      if (issue) begin
        based_r <= base_r;
        base_r  <= base_r + PW'(ROW_BITS);
      end
      if (cmd.scan_step) begin
        run_r   <= run_nxt;
        at_r    <= at_nxt;
        found_r <= found_nxt;
      end
    end

    if (cmd.resp_ld) begin
      res_status           <= fail ? STAT_NO_SPACE : STAT_OK;
      res_granted_start    <= (fail || op_r == OP_FREE) ? '0 : at_r[START_W-1:0];
      res_allocation_total <= count_nxt;
    end
  end

  assign stat.div_done  = (div_cnt_r == '0);
  assign stat.scan_done = found_r || (!pend_r && (base_r >= lim_r));
  assign stat.found     = found_r;
  assign stat.wr_done   = !pend_r && (base_r >= lim_r);
  assign stat.clr_last  = (clr_r == RW'(ROWS - 1));
  assign stat.op_free   = (op_r == OP_FREE);

endmodule
`default_nettype wire

// ===== src/bitmap_contiguous_sector_allocator.sv =====
// Top level of the first-fit contiguous sector allocator.
//
//  channel  direction  payload
//  in_      in         tuser: opcode; tdata: size_bytes, run_start
//  out_     out        tuser: status; tdata: granted_start, allocation_total
//  cfg_     in         write enable, register index, write data
//
// An item passes accept, a reciprocal size divide, setup, two pipelined map
// passes (a scan that reads the 8-sector map rows of the window and a write of
// the rows of the run) and the result; a free or a failed allocate makes one
// pass. One row is read per cycle. After reset a clearing pass writes every
// map row before the first item is taken. A new item is taken while the last
// result waits on out_tready; the result of the next item holds until taken.
`default_nettype none
module bitmap_contiguous_sector_allocator
  import bcsa_pkg::*;
#(
  parameter int NUM_SECTORS  = DEF_NUM_SECTORS,
  parameter int SECTOR_BYTES = DEF_SECTOR_BYTES
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // size_bytes[17:0], run_start[25:18]
  input  wire logic [0:0]            in_tuser,   // opcode[0]
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // granted_start[7:0], allocation_total[13:8]
  output logic [0:0]                 out_tuser,  // status[0]
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [START_W-1:0] win_start_r;
  logic [COUNT_W-1:0] data_count_r;

  cmd_t  cmd;
  stat_t stat;

  logic               res_status;
  logic [START_W-1:0] res_granted_start;
  logic [TOTAL_W-1:0] res_allocation_total;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_start_r  <= START_RESET;
      data_count_r <= COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DATA_START: win_start_r  <= cfg_wdata[START_W-1:0];
        REG_DATA_COUNT: data_count_r <= cfg_wdata[COUNT_W-1:0];
        default:        data_count_r <= data_count_r;
      endcase
    end
  end

  bcsa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  bcsa_dp #(
    .NUM_SECTORS  (NUM_SECTORS),
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .in_opcode            (in_tuser[0]),
    .in_size_bytes        (in_tdata[BYTES_W-1:0]),
    .in_run_start         (in_tdata[BYTES_W +: START_W]),
    .win_start            (win_start_r),
    .data_count           (data_count_r),
    .res_status           (res_status),
    .res_granted_start    (res_granted_start),
    .res_allocation_total (res_allocation_total)
  );

  assign out_tuser = res_status;
  assign out_tdata = {{(OUT_DATA_W - START_W - TOTAL_W){1'b0}},
                      res_allocation_total, res_granted_start};

endmodule
`default_nettype wire
